@@ rtl/efppf_pkg.sv @@
// Shared types, constants and codes for the Ethernet frame class and port filter.
`default_nettype none

package efppf_pkg;

  // Default width of the accepted-frame counter.
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // Entries in the queue between the capture front and the filter back.
  localparam int QUEUE_DEPTH = 2;

  // Width of the configuration index; wide enough to address past the list.
  localparam int CFG_INDEX_WIDTH = 8;

  // Ethertypes of interest.
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  // IP protocol numbers.
  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  // Byte offsets within the frame.
  localparam logic [6:0] POS_ETYPE_HI    = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO    = 7'd13;
  localparam logic [6:0] POS_IP_HDR      = 7'd14;
  localparam logic [6:0] POS_V4_PROTO    = 7'd23;
  localparam logic [6:0] POS_V6_NEXT_HDR = 7'd20;
  localparam logic [6:0] POS_V4_PORTS    = 7'd34;
  localparam logic [6:0] POS_V6_PORTS    = 7'd54;
  localparam logic [6:0] POS_MAX         = 7'd127;

  // Minimum frame lengths.
  localparam logic [7:0] LEN_ETH_MIN   = 8'd14;
  localparam logic [7:0] LEN_V4_MIN    = 8'd24;
  localparam logic [7:0] LEN_V6_MIN    = 8'd21;
  localparam logic [7:0] LEN_V4_PORTS  = 8'd38;
  localparam logic [7:0] LEN_V6_PORTS  = 8'd58;

  // Frame class codes.
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_ICMP  = 3'd1;
  localparam logic [2:0] CLS_TCP   = 3'd2;
  localparam logic [2:0] CLS_UDP   = 3'd3;
  localparam logic [2:0] CLS_ARP   = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLASS_ENABLE_MASK = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PORT_MATCH_ENABLE = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MATCH_PORT        = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRAME_LIMIT       = 8'd3;

  // One input transaction: a frame byte and its end-of-frame mark.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_t;

  // One result transaction.
  typedef struct packed {
    logic        accepted;
    logic [2:0]  frame_class;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [31:0] accepted_total;
    logic        limit_reached;
  } out_t;

  // Per-frame summary handed from the capture front to the filter back.
  typedef struct packed {
    logic [2:0]  frame_class;
    logic        ports_ok;
    logic [15:0] source_port;
    logic [15:0] destination_port;
  } summary_t;

  // Configuration registers as seen by the filter back.
  typedef struct packed {
    logic [3:0]  class_enable_mask;
    logic        port_match_enable;
    logic [15:0] match_port;
    logic [31:0] frame_limit;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/efppf_front.sv @@
// Capture front: tracks byte position, captures header fields, classifies each frame.
`default_nettype none

module efppf_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire efppf_pkg::in_t    in_data,
  output logic                   push,
  output efppf_pkg::summary_t    summary
);

  logic [6:0]  pos;
  logic [15:0] ethertype;
  logic [7:0]  protocol;
  logic [15:0] src_port;
  logic [15:0] dst_port;

  logic [15:0] ethertype_next;
  logic [7:0]  protocol_next;
  logic [15:0] src_port_next;
  logic [15:0] dst_port_next;
  logic        is_v4;
  logic        is_v6;
  logic [6:0]  base;
  logic [7:0]  len;
  logic [7:0]  port_end;
  logic [2:0]  cls;
  logic        ports_ok;
  logic [7:0]  b;

  assign b = in_data.frame_byte;

  // Field capture, including the byte being taken this cycle.
  always_comb begin
    ethertype_next = ethertype;
    if (pos == efppf_pkg::POS_ETYPE_HI) begin
      ethertype_next[15:8] = b;
    end else if (pos == efppf_pkg::POS_ETYPE_LO) begin
      ethertype_next[7:0] = b;
    end
    is_v4 = (ethertype_next == efppf_pkg::ETH_IPV4);
    is_v6 = (ethertype_next == efppf_pkg::ETH_IPV6);
    base  = is_v4 ? efppf_pkg::POS_V4_PORTS : efppf_pkg::POS_V6_PORTS;

    protocol_next = protocol;
    if ((is_v4 && pos == efppf_pkg::POS_V4_PROTO) ||
        (is_v6 && pos == efppf_pkg::POS_V6_NEXT_HDR)) begin
      protocol_next = b;
    end

    src_port_next = src_port;
    dst_port_next = dst_port;
    if ((is_v4 || is_v6) && pos >= efppf_pkg::POS_IP_HDR) begin
      if (pos == base) begin
        src_port_next[15:8] = b;
      end else if (pos == base + 7'd1) begin
        src_port_next[7:0] = b;
      end else if (pos == base + 7'd2) begin
        dst_port_next[15:8] = b;
      end else if (pos == base + 7'd3) begin
        dst_port_next[7:0] = b;
      end
    end
  end

  // Classification of the frame that ends with this byte.
  always_comb begin
    len      = {1'b0, pos} + 8'd1;
    cls      = efppf_pkg::CLS_OTHER;
    port_end = 8'd0;
    if (len >= efppf_pkg::LEN_ETH_MIN) begin
      if (ethertype_next == efppf_pkg::ETH_ARP) begin
        cls = efppf_pkg::CLS_ARP;
      end else if (is_v4 && len >= efppf_pkg::LEN_V4_MIN) begin
        port_end = efppf_pkg::LEN_V4_PORTS;
        if (protocol_next == efppf_pkg::PROTO_ICMP) begin
          cls = efppf_pkg::CLS_ICMP;
        end else if (protocol_next == efppf_pkg::PROTO_TCP) begin
          cls = efppf_pkg::CLS_TCP;
        end else if (protocol_next == efppf_pkg::PROTO_UDP) begin
          cls = efppf_pkg::CLS_UDP;
        end
      end else if (is_v6 && len >= efppf_pkg::LEN_V6_MIN) begin
        port_end = efppf_pkg::LEN_V6_PORTS;
        if (protocol_next == efppf_pkg::PROTO_ICMPV6) begin
          cls = efppf_pkg::CLS_ICMP;
        end else if (protocol_next == efppf_pkg::PROTO_TCP) begin
          cls = efppf_pkg::CLS_TCP;
        end else if (protocol_next == efppf_pkg::PROTO_UDP) begin
          cls = efppf_pkg::CLS_UDP;
        end
      end
    end
    ports_ok = (cls == efppf_pkg::CLS_TCP || cls == efppf_pkg::CLS_UDP) &&
               (len >= port_end);

    summary.frame_class      = cls;
    summary.ports_ok         = ports_ok;
    summary.source_port      = ports_ok ? src_port_next : 16'd0;
    summary.destination_port = ports_ok ? dst_port_next : 16'd0;
  end

  assign push = take && in_data.last_byte;

  // Position and capture registers; everything clears after the last byte.
  always_ff @(posedge clk) begin
    if (rst || push) begin
      pos       <= 7'd0;
      ethertype <= 16'd0;
      protocol  <= 8'd0;
      src_port  <= 16'd0;
      dst_port  <= 16'd0;
    end else if (take) begin
      if (pos != efppf_pkg::POS_MAX) begin
        pos <= pos + 7'd1;
      end
      ethertype <= ethertype_next;
      protocol  <= protocol_next;
      src_port  <= src_port_next;
      dst_port  <= dst_port_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/efppf_queue.sv @@
// Short queue of frame summaries between the capture front and the filter back.
`default_nettype none

module efppf_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire efppf_pkg::summary_t  push_data,
  output logic                      full,
  output logic                      valid,
  input  wire logic                 pop,
  output efppf_pkg::summary_t       pop_data
);

  localparam int PTR_W = (efppf_pkg::QUEUE_DEPTH > 1) ? $clog2(efppf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(efppf_pkg::QUEUE_DEPTH + 1);

  efppf_pkg::summary_t entries [efppf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(efppf_pkg::QUEUE_DEPTH));
  assign valid    = (fill != '0);
  assign pop_data = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(efppf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(efppf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/efppf_back.sv @@
// Filter back: applies class enables and port match, counts accepted frames, holds the result.
`default_nettype none

module efppf_back #(
  parameter int COUNT_WIDTH = efppf_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire efppf_pkg::cfg_t      cfg,
  input  wire logic                 q_valid,
  input  wire efppf_pkg::summary_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output efppf_pkg::out_t           out_data
);

  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   stopped;
  logic                   acc;
  logic                   port_hit;
  logic                   reached;
  logic                   emit;

  // Take a summary whenever the output register is free or being emptied.
  assign q_pop = q_valid && (!out_valid || out_ready);
  assign emit  = q_pop && !stopped;

  // Acceptance decision for the summary at the head of the queue.
  always_comb begin
    port_hit = (cfg.match_port == q_data.source_port) ||
               (cfg.match_port == q_data.destination_port);
    case (q_data.frame_class)
      efppf_pkg::CLS_ICMP: acc = cfg.class_enable_mask[0];
      efppf_pkg::CLS_ARP:  acc = cfg.class_enable_mask[3];
      efppf_pkg::CLS_TCP:  acc = q_data.ports_ok && cfg.class_enable_mask[1] &&
                                 (!cfg.port_match_enable || port_hit);
      efppf_pkg::CLS_UDP:  acc = q_data.ports_ok && cfg.class_enable_mask[2] &&
                                 (!cfg.port_match_enable || port_hit);
      default:             acc = 1'b0;
    endcase
    count_next = count;
    if (acc && count != '1) begin
      count_next = count + 1'b1;
    end
    reached = (CMP_W'(count_next) >= CMP_W'(cfg.frame_limit));
  end

  // Counter and sticky stop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      stopped <= 1'b0;
    end else if (emit) begin
      count <= count_next;
      if (reached) begin
        stopped <= 1'b1;
      end
    end
  end

  // Output valid; summaries arriving after the stop are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.accepted         <= acc;
      out_data.frame_class      <= q_data.frame_class;
      out_data.source_port      <= q_data.source_port;
      out_data.destination_port <= q_data.destination_port;
      out_data.accepted_total   <= 32'(count_next);
      out_data.limit_reached    <= reached;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ethernet_frame_protocol_port_filter_unit.sv @@
// Top level of the Ethernet frame class and port filter.
//
// Frame bytes enter on the in channel (in_valid/in_ready, in_data) one per
// transaction in wire order, with last_byte set on the final byte. Each
// frame that ends before the stop produces one result transaction on the
// out channel (out_valid/out_ready, out_data), carrying the class, the
// captured ports, the acceptance decision and the running accepted count.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, unknown indexes are
// dropped, and writes are meant for idle periods only.
// Throughput is one byte per cycle while in_ready is high. The capture
// front forms each summary at the frame's last byte; it is written to the
// summary queue, then registered in the filter back's output register.
// When the receiver stalls, finished summaries wait in a two-entry queue;
// in_ready falls only when that queue is full.
// Reset clears the byte position, the captures, the accepted count and
// the stop flag, and loads the register defaults (all classes enabled,
// no port match, frame limit one).
`default_nettype none

module ethernet_frame_protocol_port_filter_unit #(
  parameter int COUNT_WIDTH = efppf_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire efppf_pkg::in_t                        in_data,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output efppf_pkg::out_t                            out_data,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [efppf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                           cfg_data
);

  efppf_pkg::cfg_t     cfg;
  efppf_pkg::summary_t front_summary;
  efppf_pkg::summary_t q_data;
  logic                front_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.class_enable_mask <= 4'hF;
      cfg.port_match_enable <= 1'b0;
      cfg.match_port        <= 16'd0;
      cfg.frame_limit       <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        efppf_pkg::CFG_CLASS_ENABLE_MASK: cfg.class_enable_mask <= cfg_data[3:0];
        efppf_pkg::CFG_PORT_MATCH_ENABLE: cfg.port_match_enable <= cfg_data[0];
        efppf_pkg::CFG_MATCH_PORT:        cfg.match_port        <= cfg_data[15:0];
        efppf_pkg::CFG_FRAME_LIMIT:       cfg.frame_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  efppf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_data (in_data),
    .push    (front_push),
    .summary (front_summary)
  );

  efppf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_summary),
    .full      (q_full),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  efppf_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Ethernet frame class and port filter.
`default_nettype none

module testbench;
  import efppf_pkg::*;

  // Tracks the filter state byte by byte and holds the verdicts still owed by the block.
  class verdict_scoreboard;
    logic [3:0]  class_mask;
    logic        port_match_on;
    logic [15:0] match_port;
    logic [31:0] frame_limit;
    logic [6:0]  position;
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] accepted_count;
    logic        stopped;
    out_t        pending_verdicts[$];
    int          errors;

    function new();
      class_mask     = 4'hF;
      port_match_on  = 1'b0;
      match_port     = '0;
      frame_limit    = 32'd1;
      accepted_count = '0;
      stopped        = 1'b0;
      errors         = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      position  = '0;
      ethertype = '0;
      protocol  = '0;
      src_port  = '0;
      dst_port  = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [31:0] value);
      case (index)
        CFG_CLASS_ENABLE_MASK: class_mask = value[3:0];
        CFG_PORT_MATCH_ENABLE: port_match_on = value[0];
        CFG_MATCH_PORT:        match_port = value[15:0];
        CFG_FRAME_LIMIT:       frame_limit = value;
        default: ;
      endcase
    endfunction

    // Maps the captured protocol to a class; the ICMP number depends on the IP version.
    function logic [2:0] ip_class(logic [7:0] icmp_proto);
      if (protocol == icmp_proto) return CLS_ICMP;
      if (protocol == PROTO_TCP) return CLS_TCP;
      if (protocol == PROTO_UDP) return CLS_UDP;
      return CLS_OTHER;
    endfunction

    // Applies one accepted byte; on the last byte of a live frame a verdict is queued.
    function void note_byte(in_t item);
      logic [6:0] base;
      logic       has_ports;
      logic [7:0] len;
      logic [7:0] port_end;
      logic [7:0] b;
      out_t       verdict;
      b = item.frame_byte;
      if (!stopped) begin
        if (position == POS_ETYPE_HI) ethertype[15:8] = b;
        else if (position == POS_ETYPE_LO) ethertype[7:0] = b;
        has_ports = 1'b0;
        base = '0;
        if (ethertype == ETH_IPV4) begin
          if (position == POS_V4_PROTO) protocol = b;
          base = POS_V4_PORTS;
          has_ports = 1'b1;
        end else if (ethertype == ETH_IPV6) begin
          if (position == POS_V6_NEXT_HDR) protocol = b;
          base = POS_V6_PORTS;
          has_ports = 1'b1;
        end
        if (has_ports && position >= POS_IP_HDR) begin
          if (position == base) src_port[15:8] = b;
          else if (position == base + 7'd1) src_port[7:0] = b;
          else if (position == base + 7'd2) dst_port[15:8] = b;
          else if (position == base + 7'd3) dst_port[7:0] = b;
        end
      end
      if (!item.last_byte) begin
        if (position != POS_MAX) position++;
        return;
      end
      // A stopped filter still ends the frame but owes nothing.
      if (stopped) begin
        clear_frame();
        return;
      end
      len = {1'b0, position} + 8'd1;
      verdict = '0;
      port_end = '0;
      if (len >= LEN_ETH_MIN) begin
        if (ethertype == ETH_ARP) begin
          verdict.frame_class = CLS_ARP;
        end else if (ethertype == ETH_IPV4 && len >= LEN_V4_MIN) begin
          port_end = LEN_V4_PORTS;
          verdict.frame_class = ip_class(PROTO_ICMP);
        end else if (ethertype == ETH_IPV6 && len >= LEN_V6_MIN) begin
          port_end = LEN_V6_PORTS;
          verdict.frame_class = ip_class(PROTO_ICMPV6);
        end
      end
      case (verdict.frame_class)
        CLS_ICMP: verdict.accepted = class_mask[0];
        CLS_ARP:  verdict.accepted = class_mask[3];
        CLS_TCP, CLS_UDP: begin
          // Transport frames too short for both ports keep the class but are rejected.
          if (len >= port_end) begin
            verdict.source_port = src_port;
            verdict.destination_port = dst_port;
            verdict.accepted = (verdict.frame_class == CLS_TCP) ? class_mask[1] : class_mask[2];
            if (verdict.accepted && port_match_on && match_port != src_port &&
                match_port != dst_port)
              verdict.accepted = 1'b0;
          end
        end
        default: ;
      endcase
      if (verdict.accepted && accepted_count != '1) accepted_count++;
      verdict.accepted_total = accepted_count;
      verdict.limit_reached = accepted_count >= frame_limit;
      if (verdict.limit_reached) stopped = 1'b1;
      pending_verdicts.push_back(verdict);
      clear_frame();
    endfunction

    // Compares one result transaction with the oldest pending verdict.
    function void check_verdict(out_t got);
      out_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with no verdict pending: %h", got);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.frame_class !== want.frame_class) begin
        $error("frame_class: expected %0d, got %0d", want.frame_class, got.frame_class);
        errors++;
      end
      if (got.source_port !== want.source_port) begin
        $error("source_port: expected %h, got %h", want.source_port, got.source_port);
        errors++;
      end
      if (got.destination_port !== want.destination_port) begin
        $error("destination_port: expected %h, got %h", want.destination_port,
               got.destination_port);
        errors++;
      end
      if (got.accepted_total !== want.accepted_total) begin
        $error("accepted_total: expected %0d, got %0d", want.accepted_total,
               got.accepted_total);
        errors++;
      end
      if (got.limit_reached !== want.limit_reached) begin
        $error("limit_reached: expected %0d, got %0d", want.limit_reached, got.limit_reached);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  in_t                        in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_t                       out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [31:0]                cfg_data = '0;

  verdict_scoreboard book = new();
  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int bytes_sent = 0;

  ethernet_frame_protocol_port_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one byte until it is taken, then idles for a random stretch.
  task automatic send_byte(input logic [7:0] value, input logic last);
    in_t item;
    int  gap;
    item.frame_byte = value;
    item.last_byte = last;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    book.note_byte(item);
    bytes_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a frame of random bytes with the ethertype, protocol and ports laid in place.
  task automatic send_frame(input logic [15:0] etype, input logic [7:0] proto, input int len,
                            input logic [15:0] sp, input logic [15:0] dp);
    int         base;
    logic [7:0] b;
    base = (etype == ETH_IPV6) ? POS_V6_PORTS : POS_V4_PORTS;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == POS_ETYPE_HI) b = etype[15:8];
      else if (i == POS_ETYPE_LO) b = etype[7:0];
      else if (etype == ETH_IPV4 && i == POS_V4_PROTO) b = proto;
      else if (etype == ETH_IPV6 && i == POS_V6_NEXT_HDR) b = proto;
      else if (i == base) b = sp[15:8];
      else if (i == base + 1) b = sp[7:0];
      else if (i == base + 2) b = dp[15:8];
      else if (i == base + 3) b = dp[7:0];
      send_byte(b, i == len - 1);
    end
  endtask

  // Mostly well-formed frames with random content, plus truncated ones and noise.
  task automatic random_frame();
    int          pick;
    int          r;
    int          len;
    int          n;
    logic [15:0] etype;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  proto;
    int          v4_edges[6] = '{13, 14, 23, 24, 37, 38};
    int          v6_edges[5] = '{13, 20, 21, 57, 58};
    logic [15:0] near_miss[4] = '{16'h0801, 16'h0807, 16'h86DC, 16'h0000};
    r = $urandom_range(0, 9);
    if (r == 0) proto = PROTO_ICMP;
    else if (r == 1) proto = PROTO_ICMPV6;
    else if (r < 5) proto = PROTO_TCP;
    else if (r < 8) proto = PROTO_UDP;
    else proto = 8'($urandom);
    sp = 16'($urandom);
    dp = 16'($urandom);
    case ($urandom_range(0, 6))
      0: sp = book.match_port;
      1: dp = book.match_port;
      2: begin
        sp = book.match_port;
        dp = book.match_port;
      end
      3: begin
        sp = '0;
        dp = '1;
      end
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (pick < 40) begin
      etype = ETH_IPV4;
      if (r < 82) len = $urandom_range(38, 46);
      else if (r < 96) len = v4_edges[$urandom_range(0, 5)];
      else len = $urandom_range(128, 180);
    end else if (pick < 70) begin
      etype = ETH_IPV6;
      if (r < 82) len = $urandom_range(58, 64);
      else if (r < 96) len = v6_edges[$urandom_range(0, 4)];
      else len = $urandom_range(128, 180);
    end else if (pick < 80) begin
      etype = ETH_ARP;
      len = $urandom_range(13, 42);
    end else if (pick < 90) begin
      etype = (r < 50) ? near_miss[$urandom_range(0, 3)] : 16'($urandom);
      len = $urandom_range(1, 60);
    end else begin
      // Raw noise with end marks at random, closed at the end of the burst.
      n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), i == n - 1 || $urandom_range(0, 15) == 0);
      return;
    end
    send_frame(etype, proto, len, sp, dp);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(index, value);
  endtask

  // Stops offering bytes and waits until every pending verdict has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: checks each result transaction and stalls at random or on request.
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) book.check_verdict(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall = draw_gap();
      end
    end
  end

  // Stimulus: directed frames, several register settings, then the stop.
  initial begin
    int          target;
    logic [31:0] limit;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Open the limit so the default of one does not stop the filter at once.
    write_reg(CFG_FRAME_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_CLASS_ENABLE_MASK, 32'hF);
    write_reg(CFG_PORT_MATCH_ENABLE, 32'd0);
    write_reg(CFG_MATCH_PORT, 32'd0);
    // Indexes past the register list must be dropped.
    write_reg(CFG_FRAME_LIMIT + 8'd1, $urandom);
    write_reg('1, $urandom);
    cfg_valid <= 1'b0;

    // Directed frames: length boundaries, ICMP pairing, ARP, long and foreign frames.
    send_frame(ETH_IPV4, PROTO_TCP, 38, 16'hFFFF, 16'h0000);
    send_frame(ETH_IPV4, PROTO_UDP, 37, 16'h1234, 16'h5678);
    send_frame(ETH_IPV4, PROTO_ICMP, 24, 16'h0, 16'h0);
    send_frame(ETH_IPV4, PROTO_ICMP, 23, 16'h0, 16'h0);
    send_frame(ETH_IPV4, PROTO_ICMPV6, 40, 16'h0, 16'h0);
    send_frame(ETH_IPV6, PROTO_ICMPV6, 21, 16'h0, 16'h0);
    send_frame(ETH_IPV6, PROTO_ICMPV6, 20, 16'h0, 16'h0);
    send_frame(ETH_IPV6, PROTO_ICMP, 30, 16'h0, 16'h0);
    send_frame(ETH_IPV6, PROTO_TCP, 58, 16'h0000, 16'hFFFF);
    send_frame(ETH_IPV6, PROTO_UDP, 57, 16'hAAAA, 16'h5555);
    send_frame(ETH_ARP, 8'h00, 14, 16'h0, 16'h0);
    send_frame(ETH_ARP, 8'h00, 13, 16'h0, 16'h0);
    send_frame(16'h0000, 8'h00, 1, 16'h0, 16'h0);
    send_frame(ETH_IPV4, PROTO_UDP, 200, 16'h8001, 16'h7FFE);
    send_frame(16'hFFFF, 8'hFF, 60, 16'h0, 16'h0);
    send_frame(ETH_IPV4, 8'h00, 40, 16'h0, 16'h0);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 1; phase <= 7; phase++) begin
      write_reg(CFG_CLASS_ENABLE_MASK,
                phase == 1 ? 32'h0 : phase == 2 ? 32'hF : $urandom_range(0, 15));
      write_reg(CFG_PORT_MATCH_ENABLE, (phase % 2 == 0) ? 32'd1 : 32'd0);
      write_reg(CFG_MATCH_PORT,
                phase == 2 ? 32'hFFFF : phase == 4 ? 32'h0 : $urandom_range(0, 65535));
      cfg_valid <= 1'b0;
      calm = (phase == 3 || phase == 6);
      if (phase == 4) begin
        // Long receiver stall while short frames keep coming, so the input backs up.
        hold_request = 1'b1;
        repeat (12) send_frame(ETH_ARP, 8'h00, $urandom_range(1, 14), 16'h0, 16'h0);
      end
      target = bytes_sent + 50;
      while (bytes_sent < target) random_frame();
      drain();
    end
    calm = 1'b0;

    // Lower the limit so the filter stops, then confirm that nothing more comes out.
    write_reg(CFG_CLASS_ENABLE_MASK, 32'hF);
    write_reg(CFG_PORT_MATCH_ENABLE, 32'd0);
    limit = ($urandom_range(0, 3) == 0) ? 32'd0 : book.accepted_count + $urandom_range(1, 4);
    write_reg(CFG_FRAME_LIMIT, limit);
    cfg_valid <= 1'b0;
    while (!book.stopped) random_frame();
    repeat (4) random_frame();
    drain();

    if (book.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
